/* sv/mi3_pkg.sv */
// ----------------------------------------------------------------------------
// mi3_pkg
// Shared constants for the 3x3 matrix inverse: register map and cofactor
// operand table.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int AddrWidth = 3;

    typedef enum logic [0:0] {
        REG_SYMMETRIC = 1'b0
    } mi3_reg_t;

    // Adjugate entry i = a[P]*a[Q] - a[R]*a[S] (transposed cofactors), in row-major order
    localparam logic [3:0] COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

endpackage

/* sv/mi3_if.sv */
// ----------------------------------------------------------------------------
// mi3_in_if / mi3_out_if
// Valid/ready channels carrying one matrix item and one inverse item.
// ----------------------------------------------------------------------------
interface mi3_in_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] a00;
    logic signed [DATA_WIDTH-1:0] a01;
    logic signed [DATA_WIDTH-1:0] a02;
    logic signed [DATA_WIDTH-1:0] a10;
    logic signed [DATA_WIDTH-1:0] a11;
    logic signed [DATA_WIDTH-1:0] a12;
    logic signed [DATA_WIDTH-1:0] a20;
    logic signed [DATA_WIDTH-1:0] a21;
    logic signed [DATA_WIDTH-1:0] a22;

    modport source (output valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    input ready);
    modport sink   (input valid, a00, a01, a02, a10, a11, a12, a20, a21, a22,
                    output ready);
endinterface

interface mi3_out_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] inv00;
    logic signed [DATA_WIDTH-1:0] inv01;
    logic signed [DATA_WIDTH-1:0] inv02;
    logic signed [DATA_WIDTH-1:0] inv10;
    logic signed [DATA_WIDTH-1:0] inv11;
    logic signed [DATA_WIDTH-1:0] inv12;
    logic signed [DATA_WIDTH-1:0] inv20;
    logic signed [DATA_WIDTH-1:0] inv21;
    logic signed [DATA_WIDTH-1:0] inv22;
    logic                         singular;

    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, input ready);
    modport sink   (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, output ready);
endinterface

/* sv/matrix_inverse_3x3.sv */
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 fixed-point inverse: adjugate divided by determinant.
// ----------------------------------------------------------------------------
// Accepts one matrix item per cycle while the output is not stalled and
// returns its inverse. The quotient pipeline has one restoring-division
// stage per quotient bit, DATA_WIDTH+1 of them, each running the nine
// entries side by side. Every full stage holds when its successor holds,
// so empty stages are squeezed out under back pressure. Results are
// truncated toward zero and saturated; a zero determinant gives singular=1
// and all-zero entries. symmetric_mode (APB address 0, bit 0) mirrors
// a01, a02, a12 into a10, a20, a21.
module matrix_inverse_3x3 #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [mi3_pkg::AddrWidth-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    mi3_in_if.sink                   in_ch,
    mi3_out_if.source                out_ch
);
    import mi3_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;
    localparam int HW = 2 * W + 1;
    localparam int TW = 3 * W + 2;
    localparam int DW = 3 * W + 3;
    localparam int NW = CW + 2 * F;
    localparam int XB = DW + W + 2;
    localparam int XW = (NW > XB) ? NW : XB;
    localparam int D  = W + 1;

    localparam logic [W:0]   QMAX   = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   QMIN   = {2'b01, {(W-1){1'b0}}};
    localparam logic [W-1:0] MAXPOS = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] MINNEG = {1'b1, {(W-1){1'b0}}};

    // configuration
    logic sym_reg;

    assign pready = 1'b1;
    assign prdata = {{31{1'b0}}, sym_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready &&
                 paddr == {REG_SYMMETRIC, 2'b00})
        begin
            sym_reg <= pwdata[0];
        end
    end

    // stage enables
    logic en_out, en1, en2, en3, en4, en5, en6, en7;
    logic en_dv [D+1];
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, out_v_reg;
    logic dv_v_reg [D+1];

    assign en_out = !out_v_reg || out_ch.ready;
    assign en_dv[D] = !dv_v_reg[D] || en_out;
    for (genvar j = 0; j < D; j++)
    begin : g_en
        assign en_dv[j] = !dv_v_reg[j] || en_dv[j+1];
    end
    assign en7 = !v7_reg || en_dv[0];
    assign en6 = !v6_reg || en7;
    assign en5 = !v5_reg || en6;
    assign en4 = !v4_reg || en5;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;
    assign in_ch.ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
            dv_v_reg[0] <= 1'b0;
            out_v_reg <= 1'b0;
        end
        else
        begin
            if (en1)       v1_reg      <= in_ch.valid;
            if (en2)       v2_reg      <= v1_reg;
            if (en3)       v3_reg      <= v2_reg;
            if (en4)       v4_reg      <= v3_reg;
            if (en5)       v5_reg      <= v4_reg;
            if (en6)       v6_reg      <= v5_reg;
            if (en7)       v7_reg      <= v6_reg;
            if (en_dv[0])  dv_v_reg[0] <= v7_reg;
            if (en_out)    out_v_reg   <= dv_v_reg[D];
        end
    end

    // stage 1: input capture with optional mirroring
    logic signed [W-1:0] s1_a_reg [9];

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_a_reg[0] <= in_ch.a00;
            s1_a_reg[1] <= in_ch.a01;
            s1_a_reg[2] <= in_ch.a02;
            s1_a_reg[3] <= sym_reg ? in_ch.a01 : in_ch.a10;
            s1_a_reg[4] <= in_ch.a11;
            s1_a_reg[5] <= in_ch.a12;
            s1_a_reg[6] <= sym_reg ? in_ch.a02 : in_ch.a20;
            s1_a_reg[7] <= sym_reg ? in_ch.a12 : in_ch.a21;
            s1_a_reg[8] <= in_ch.a22;
        end
    end

    // stage 2: cofactor products
    logic signed [PW-1:0] s2_pa_reg [9];
    logic signed [PW-1:0] s2_pb_reg [9];
    logic signed [W-1:0]  s2_a_reg  [3];

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            for (int i = 0; i < 9; i++)
            begin
                s2_pa_reg[i] <= s1_a_reg[COF_IDX[i][0]] * s1_a_reg[COF_IDX[i][1]];
                s2_pb_reg[i] <= s1_a_reg[COF_IDX[i][2]] * s1_a_reg[COF_IDX[i][3]];
            end
            for (int k = 0; k < 3; k++)
            begin
                s2_a_reg[k] <= s1_a_reg[k];
            end
        end
    end

    // stage 3: cofactors
    logic signed [CW-1:0] s3_c_reg [9];
    logic signed [W-1:0]  s3_a_reg [3];

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            for (int i = 0; i < 9; i++)
            begin
                s3_c_reg[i] <= CW'(s2_pa_reg[i]) - CW'(s2_pb_reg[i]);
            end
            for (int k = 0; k < 3; k++)
            begin
                s3_a_reg[k] <= s2_a_reg[k];
            end
        end
    end

    // stage 4: determinant partial products, cofactor split in two halves
    logic signed [HW-1:0] s4_ph_reg [3];
    logic signed [HW-1:0] s4_pl_reg [3];
    logic signed [CW-1:0] s4_c_reg  [9];

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s4_ph_reg[k] <= s3_a_reg[k] * $signed(s3_c_reg[3*k][CW-1:W]);
                s4_pl_reg[k] <= s3_a_reg[k] * $signed({1'b0, s3_c_reg[3*k][W-1:0]});
            end
            for (int i = 0; i < 9; i++)
            begin
                s4_c_reg[i] <= s3_c_reg[i];
            end
        end
    end

    // stage 5: determinant terms
    logic signed [TW-1:0] s5_t_reg [3];
    logic signed [CW-1:0] s5_c_reg [9];

    always_ff @(posedge clk)
    begin
        if (en5)
        begin
            for (int k = 0; k < 3; k++)
            begin
                s5_t_reg[k] <= (TW'(s4_ph_reg[k]) <<< W) + TW'(s4_pl_reg[k]);
            end
            for (int i = 0; i < 9; i++)
            begin
                s5_c_reg[i] <= s4_c_reg[i];
            end
        end
    end

    // stage 6: determinant
    logic signed [DW-1:0] s6_det_reg;
    logic signed [CW-1:0] s6_c_reg [9];

    always_ff @(posedge clk)
    begin
        if (en6)
        begin
            s6_det_reg <= DW'(s5_t_reg[0]) + DW'(s5_t_reg[1]) + DW'(s5_t_reg[2]);
            for (int i = 0; i < 9; i++)
            begin
                s6_c_reg[i] <= s5_c_reg[i];
            end
        end
    end

    // stage 7: magnitudes and signs
    logic [NW-1:0] s7_n_reg [9];
    logic [DW-1:0] s7_d_reg;
    logic          s7_neg_reg [9];
    logic          s7_sing_reg;
    logic [CW-1:0] cmag [9];
    logic [DW-1:0] dmag;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            cmag[i] = s6_c_reg[i][CW-1] ? CW'(-s6_c_reg[i]) : CW'(s6_c_reg[i]);
        end
        dmag = s6_det_reg[DW-1] ? DW'(-s6_det_reg) : DW'(s6_det_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en7)
        begin
            for (int i = 0; i < 9; i++)
            begin
                s7_n_reg[i]   <= NW'(cmag[i]) << (2 * F);
                s7_neg_reg[i] <= s6_c_reg[i][CW-1] ^ s6_det_reg[DW-1];
            end
            s7_d_reg    <= dmag;
            s7_sing_reg <= (s6_det_reg == '0);
        end
    end

    // quotient pipeline: stage 0 checks for a quotient of 2^(W+1) or more,
    // stage j+1 decides quotient bit W-j
    logic [XW-1:0] dv_rem_reg  [D+1][9];
    logic [W:0]    dv_q_reg    [D+1][9];
    logic          dv_neg_reg  [D+1][9];
    logic          dv_ovf_reg  [D+1][9];
    logic [DW-1:0] dv_d_reg    [D+1];
    logic          dv_sing_reg [D+1];

    always_ff @(posedge clk)
    begin
        if (en_dv[0])
        begin
            for (int i = 0; i < 9; i++)
            begin
                dv_rem_reg[0][i] <= XW'(s7_n_reg[i]);
                dv_q_reg[0][i]   <= '0;
                dv_neg_reg[0][i] <= s7_neg_reg[i];
                dv_ovf_reg[0][i] <= XW'(s7_n_reg[i]) >= (XW'(s7_d_reg) << (W + 1));
            end
            dv_d_reg[0]    <= s7_d_reg;
            dv_sing_reg[0] <= s7_sing_reg;
        end
    end

    for (genvar j = 0; j < D; j++)
    begin : g_div
        localparam int K = W - j;
        logic [XW-1:0] dsh;

        assign dsh = XW'(dv_d_reg[j]) << K;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_v_reg[j+1] <= 1'b0;
            end
            else if (en_dv[j+1])
            begin
                dv_v_reg[j+1] <= dv_v_reg[j];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en_dv[j+1])
            begin
                for (int i = 0; i < 9; i++)
                begin
                    if (dv_rem_reg[j][i] >= dsh)
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i] - dsh;
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i] | ((W+1)'(1) << K);
                    end
                    else
                    begin
                        dv_rem_reg[j+1][i] <= dv_rem_reg[j][i];
                        dv_q_reg[j+1][i]   <= dv_q_reg[j][i];
                    end
                    dv_neg_reg[j+1][i] <= dv_neg_reg[j][i];
                    dv_ovf_reg[j+1][i] <= dv_ovf_reg[j][i];
                end
                dv_d_reg[j+1]    <= dv_d_reg[j];
                dv_sing_reg[j+1] <= dv_sing_reg[j];
            end
        end
    end

    // sign, saturation and output register
    logic [W-1:0] res [9];
    logic [W-1:0] out_res_reg [9];
    logic         out_sing_reg;

    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            if (dv_sing_reg[D])
                res[i] = '0;
            else if (dv_ovf_reg[D][i])
                res[i] = dv_neg_reg[D][i] ? MINNEG : MAXPOS;
            else if (!dv_neg_reg[D][i])
                res[i] = (dv_q_reg[D][i] > QMAX) ? MAXPOS : dv_q_reg[D][i][W-1:0];
            else if (dv_q_reg[D][i] > QMIN)
                res[i] = MINNEG;
            else
                res[i] = W'(-dv_q_reg[D][i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en_out)
        begin
            for (int i = 0; i < 9; i++)
            begin
                out_res_reg[i] <= res[i];
            end
            out_sing_reg <= dv_sing_reg[D];
        end
    end

    assign out_ch.valid    = out_v_reg;
    assign out_ch.inv00    = out_res_reg[0];
    assign out_ch.inv01    = out_res_reg[1];
    assign out_ch.inv02    = out_res_reg[2];
    assign out_ch.inv10    = out_res_reg[3];
    assign out_ch.inv11    = out_res_reg[4];
    assign out_ch.inv12    = out_res_reg[5];
    assign out_ch.inv20    = out_res_reg[6];
    assign out_ch.inv21    = out_res_reg[7];
    assign out_ch.inv22    = out_res_reg[8];
    assign out_ch.singular = out_sing_reg;

endmodule

/* sv/mi3_checker.sv */
// ----------------------------------------------------------------------------
// mi3_checker
// Port-level checks for matrix_inverse_3x3, bound to the top level.
// ----------------------------------------------------------------------------
module mi3_checker #(
    parameter int W = 32
) (
    input logic         clk,
    input logic         rst_n,
    input logic         pready,
    input logic         out_valid,
    input logic         out_ready,
    input logic         singular,
    input logic [W-1:0] inv00,
    input logic [W-1:0] inv01,
    input logic [W-1:0] inv02,
    input logic [W-1:0] inv10,
    input logic [W-1:0] inv11,
    input logic [W-1:0] inv12,
    input logic [W-1:0] inv20,
    input logic [W-1:0] inv21,
    input logic [W-1:0] inv22
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(singular) && $stable(inv00)
            && $stable(inv11) && $stable(inv22))
        else $error("output item changed while stalled");

    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && singular |-> inv00 == '0 && inv01 == '0 && inv02 == '0
            && inv10 == '0 && inv11 == '0 && inv12 == '0 && inv20 == '0
            && inv21 == '0 && inv22 == '0)
        else $error("singular item with nonzero entries");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind matrix_inverse_3x3 mi3_checker #(.W(DATA_WIDTH)) u_mi3_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pready    (pready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .singular  (out_ch.singular),
    .inv00     (out_ch.inv00),
    .inv01     (out_ch.inv01),
    .inv02     (out_ch.inv02),
    .inv10     (out_ch.inv10),
    .inv11     (out_ch.inv11),
    .inv12     (out_ch.inv12),
    .inv20     (out_ch.inv20),
    .inv21     (out_ch.inv21),
    .inv22     (out_ch.inv22)
);
